// ===== rtl/tess_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tess_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 11;
   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_rsp;
      logic csr_write;
   } cmd_type;

   // Clamp a written capacity into 1..MAX_ENTRIES.
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (int'(c) > MAX_ENTRIES) begin
         r = CNT_W'(MAX_ENTRIES);
      end else begin
         r = CNT_W'(c);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tess_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tess_req_if;
   logic                          valid;
   logic                          ready;
   logic [tess_pkg::FUNC_W-1:0]   func;
   logic                          stack_sel;
   logic signed [tess_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output func, output stack_sel, output push_value,
                   input ready);
   modport sink (input valid, input func, input stack_sel, input push_value,
                 output ready);
endinterface

interface tess_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tess_pkg::STATUS_W-1:0]   status;
   logic signed [tess_pkg::DATA_W-1:0] read_value;
   logic                            low_empty;
   logic                            high_empty;
   logic                            store_full;

   modport source (output valid, output status, output read_value, output low_empty,
                   output high_empty, output store_full, input ready);
   modport sink (input valid, input status, input read_value, input low_empty,
                 input high_empty, input store_full, output ready);
endinterface

interface tess_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tess_pkg::CAP_W-1:0]   capacity;

   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/tess_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tess_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tess_pkg::cmd_type      cmd
);

   tess_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tess_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      csr_ready    = 1'b1;
      out_free     = !rsp_valid_ff || rsp_ready;
      cmd.csr_write = csr_valid;
      case (state_ff)
         tess_pkg::ST_IDLE: begin
            // configuration beat wins over a request beat
            req_ready  = !csr_valid;
            cmd.accept = req_valid && !csr_valid;
            if (cmd.accept) begin
               state_in = tess_pkg::ST_READ;
            end
         end
         tess_pkg::ST_READ: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = tess_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tess_pkg::ST_IDLE;
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_goes_read: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == tess_pkg::ST_READ)
      else $error("accepted beat did not enter read state");

   a_load_only_in_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> state_ff == tess_pkg::ST_READ && !cmd.accept)
      else $error("result loaded outside read state");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/tess_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tess_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tess_pkg::cmd_type                 cmd,
   input  wire logic [tess_pkg::FUNC_W-1:0]       req_func,
   input  wire logic                              req_stack_sel,
   input  wire logic signed [tess_pkg::DATA_W-1:0] req_push_value,
   input  wire logic [tess_pkg::CAP_W-1:0]        csr_capacity,
   output logic [tess_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [tess_pkg::DATA_W-1:0]     rsp_read_value,
   output logic                                   rsp_low_empty,
   output logic                                   rsp_high_empty,
   output logic                                   rsp_store_full
);

   localparam int CNT_W  = tess_pkg::CNT_W;
   localparam int ADDR_W = tess_pkg::ADDR_W;
   localparam int DATA_W = tess_pkg::DATA_W;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  used_low_ff, used_low_in;
   logic [CNT_W-1:0]  used_high_ff, used_high_in;

   logic [DATA_W-1:0] mem [tess_pkg::MAX_ENTRIES];
   logic [DATA_W-1:0] mem_q_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;

   tess_pkg::status_type pend_status_ff, pend_status_in;
   logic              pend_rd_ff, pend_rd_in;
   logic              pend_low_empty_ff, pend_high_empty_ff, pend_full_ff;

   logic [CNT_W:0]    sum_now, sum_next;
   logic              full_now;
   logic [CNT_W-1:0]  sel_used;
   logic [CNT_W-1:0]  high_push_slot, high_top_slot, low_top_slot;

   logic [tess_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_read_value_ff;
   logic              rsp_low_empty_ff, rsp_high_empty_ff, rsp_store_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= tess_pkg::eff_cap(tess_pkg::CAP_RESET);
         used_low_ff  <= '0;
         used_high_ff <= '0;
      end else begin
         cap_ff       <= cap_in;
         used_low_ff  <= used_low_in;
         used_high_ff <= used_high_in;
      end
   end

   always_comb begin
      sum_now        = {1'b0, used_low_ff} + {1'b0, used_high_ff};
      full_now       = sum_now >= {1'b0, cap_ff};
      sel_used       = req_stack_sel ? used_high_ff : used_low_ff;
      high_push_slot = cap_ff - used_high_ff - CNT_W'(1);
      high_top_slot  = cap_ff - used_high_ff;
      low_top_slot   = used_low_ff - CNT_W'(1);

      cap_in         = cap_ff;
      used_low_in    = used_low_ff;
      used_high_in   = used_high_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = '0;
      pend_status_in = tess_pkg::STATUS_OK;
      pend_rd_in     = 1'b0;

      if (cmd.csr_write) begin
         cap_in       = tess_pkg::eff_cap(csr_capacity);
         used_low_in  = '0;
         used_high_in = '0;
      end else if (cmd.accept) begin
         case (tess_pkg::func_type'(req_func))
            tess_pkg::FUNC_PUSH: begin
               if (full_now) begin
                  pend_status_in = tess_pkg::STATUS_FULL;
               end else if (!req_stack_sel) begin
                  mem_we      = 1'b1;
                  mem_addr    = used_low_ff[ADDR_W-1:0];
                  used_low_in = used_low_ff + CNT_W'(1);
               end else begin
                  mem_we       = 1'b1;
                  mem_addr     = high_push_slot[ADDR_W-1:0];
                  used_high_in = used_high_ff + CNT_W'(1);
               end
            end
            tess_pkg::FUNC_POP, tess_pkg::FUNC_PEEK: begin
               if (sel_used == '0) begin
                  pend_status_in = tess_pkg::STATUS_EMPTY;
               end else begin
                  mem_re     = 1'b1;
                  pend_rd_in = 1'b1;
                  mem_addr   = req_stack_sel ? high_top_slot[ADDR_W-1:0]
                                             : low_top_slot[ADDR_W-1:0];
                  if (tess_pkg::func_type'(req_func) == tess_pkg::FUNC_POP) begin
                     if (req_stack_sel) begin
                        used_high_in = used_high_ff - CNT_W'(1);
                     end else begin
                        used_low_in = used_low_ff - CNT_W'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      sum_next = {1'b0, used_low_in} + {1'b0, used_high_in};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_push_value;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   // capture status and flags of the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff     <= pend_status_in;
         pend_rd_ff         <= pend_rd_in;
         pend_low_empty_ff  <= used_low_in == '0;
         pend_high_empty_ff <= used_high_in == '0;
         pend_full_ff       <= sum_next >= {1'b0, cap_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff     <= pend_status_ff;
         rsp_read_value_ff <= pend_rd_ff ? mem_q_ff : '0;
         rsp_low_empty_ff  <= pend_low_empty_ff;
         rsp_high_empty_ff <= pend_high_empty_ff;
         rsp_store_full_ff <= pend_full_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_low_empty  = rsp_low_empty_ff;
   assign rsp_high_empty = rsp_high_empty_ff;
   assign rsp_store_full = rsp_store_full_ff;

   a_never_overfull: assert property (@(posedge clock) disable iff (reset)
      sum_now <= {1'b0, cap_ff})
      else $error("stacks hold more than capacity");

   a_csr_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.csr_write |=> used_low_ff == '0 && used_high_ff == '0)
      else $error("capacity write did not empty the stacks");

   a_cap_in_range: assert property (@(posedge clock) disable iff (reset)
      cap_ff != '0 && int'(cap_ff) <= tess_pkg::MAX_ENTRIES)
      else $error("effective capacity out of range");

   a_no_write_and_read: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store written and read by one beat");

endmodule

`default_nettype wire

// ===== rtl/two_ended_shared_stack_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two stacks sharing one 1024-entry store: the low stack grows up from entry 0,
// the high stack grows down from entry capacity-1.
// req_bus: one beat is a push, pop or peek (func) on one stack (stack_sel).
// rsp_bus: one beat per request with status, read_value and the occupancy flags
//    as they stand after the operation.
// csr_bus: writes the capacity register (0 acts as 1, above 1024 acts as 1024)
//    and empties both stacks; write only while no request is in flight.
// An accepted request puts the controller in its read state; the store's
//    registered read port and the pending registers capture it on entry, and its
//    result then moves into the output register that drives rsp_bus. The next
//    request is taken only after that result has moved into the output register.
// A result waiting on rsp_bus does not block the next request; if the receiver
//    stalls, that request holds in its read cycle until the output frees up.
// Reset: capacity returns to 1024, both stacks empty, no result pending.
//    Store contents are not cleared; an entry is read only after a push to it.

module two_ended_shared_stack_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tess_req_if.sink   req_bus,
   tess_rsp_if.source rsp_bus,
   tess_csr_if.sink   csr_bus
);

   tess_pkg::cmd_type cmd;

   tess_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   tess_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_bus.func),
      .req_stack_sel  (req_bus.stack_sel),
      .req_push_value (req_bus.push_value),
      .csr_capacity   (csr_bus.capacity),
      .rsp_status     (rsp_bus.status),
      .rsp_read_value (rsp_bus.read_value),
      .rsp_low_empty  (rsp_bus.low_empty),
      .rsp_high_empty (rsp_bus.high_empty),
      .rsp_store_full (rsp_bus.store_full)
   );

endmodule

`default_nettype wire

// ===== sim/tb_two_ended_shared_stack_unit.sv =====
`timescale 1ns / 1ps

module tb_two_ended_shared_stack_unit;

   localparam int FUNC_W      = tess_pkg::FUNC_W;
   localparam int DATA_W      = tess_pkg::DATA_W;
   localparam int CAP_W       = tess_pkg::CAP_W;
   localparam int MAX_ENTRIES = tess_pkg::MAX_ENTRIES;

   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 56;
   localparam int DIRECTED_ROWS   = 28;

   typedef struct packed {
      tess_pkg::status_type status;
      logic [DATA_W-1:0]    read_value;
      logic                 low_empty;
      logic                 high_empty;
      logic                 store_full;
   } stack_result_type;

   typedef struct {
      bit                cfg;
      logic [CAP_W-1:0]  cap;
      logic [FUNC_W-1:0] op;
      logic              sel;
      logic [DATA_W-1:0] val;
      bit                pinned;
      stack_result_type  res;
   } plan_row_type;

   localparam stack_result_type NO_PIN = '{tess_pkg::STATUS_OK, 32'h0, 1'b0, 1'b0, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   tess_req_if req_bus ();
   tess_rsp_if rsp_bus ();
   tess_csr_if csr_bus ();

   two_ended_shared_stack_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Shadow of the block: capacity register, stack depths and the shared store.
   logic [CAP_W-1:0]  cap_reg = tess_pkg::CAP_RESET;
   int                low_count = 0;
   int                high_count = 0;
   logic [DATA_W-1:0] shared_mem [MAX_ENTRIES];

   stack_result_type pending_results [$];
   stack_result_type pin_res = NO_PIN;
   bit               pin_on = 1'b0;
   bit               calm = 1'b0;
   bit               gaps_on = 1'b0;
   bit               stall_on = 1'b0;
   int               err_count = 0;

   function automatic stack_result_type predict_op(input logic [FUNC_W-1:0] op,
                                                   input logic sel,
                                                   input logic [DATA_W-1:0] val);
      int               cap;
      int               depth;
      int               top_idx;
      stack_result_type r;
      cap = int'(cap_reg);
      if (cap < 1) cap = 1;
      if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
      r = NO_PIN;
      depth = sel ? high_count : low_count;
      top_idx = sel ? cap - high_count : low_count - 1;
      case (op)
         tess_pkg::FUNC_PUSH: begin
            if (low_count + high_count >= cap) begin
               r.status = tess_pkg::STATUS_FULL;
            end else if (!sel) begin
               shared_mem[low_count] = val;
               low_count++;
            end else begin
               high_count++;
               shared_mem[cap - high_count] = val;
            end
         end
         tess_pkg::FUNC_POP, tess_pkg::FUNC_PEEK: begin
            if (depth == 0) begin
               r.status = tess_pkg::STATUS_EMPTY;
            end else begin
               r.read_value = shared_mem[top_idx];
               if (op == tess_pkg::FUNC_POP) begin
                  if (sel) high_count--;
                  else low_count--;
               end
            end
         end
         default: ;
      endcase
      r.low_empty  = (low_count == 0);
      r.high_empty = (high_count == 0);
      r.store_full = (low_count + high_count >= cap);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         err_count++;
      end
   endtask

   // Check result beats, then track register writes and accepted requests.
   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         cap_reg = tess_pkg::CAP_RESET;
         low_count = 0;
         high_count = 0;
         pending_results.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual status %h value %h",
                        $time, rsp_bus.status, rsp_bus.read_value);
               err_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_bus.status));
               check_field("read_value", want.read_value, rsp_bus.read_value);
               check_field("low_empty", DATA_W'(want.low_empty), DATA_W'(rsp_bus.low_empty));
               check_field("high_empty", DATA_W'(want.high_empty),
                           DATA_W'(rsp_bus.high_empty));
               check_field("store_full", DATA_W'(want.store_full),
                           DATA_W'(rsp_bus.store_full));
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            cap_reg = csr_bus.capacity;
            low_count = 0;
            high_count = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            want = predict_op(req_bus.func, req_bus.stack_sel, req_bus.push_value);
            if (pin_on) want = pin_res;
            pending_results.push_back(want);
         end
      end
   end

   // Receiver: stall in bursts while allowed.
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && stall_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic send_item(input logic [FUNC_W-1:0] op, input logic sel,
                            input logic [DATA_W-1:0] val, input bit pinned,
                            input stack_result_type res);
      pin_on = pinned;
      pin_res = res;
      req_bus.func = op;
      req_bus.stack_sel = sel;
      req_bus.push_value = val;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_bus.capacity = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   plan_row_type plan [DIRECTED_ROWS] = '{
      '{1'b0, 11'd0, tess_pkg::FUNC_POP, 1'b0, 32'h0, 1'b1,
        '{tess_pkg::STATUS_EMPTY, 32'h0, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PEEK, 1'b1, 32'hffffffff, 1'b1,
        '{tess_pkg::STATUS_EMPTY, 32'h0, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 11'd0, FUNC_NOP, 1'b0, 32'h0, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h0, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'h7fffffff, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h0, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'h80000000, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PEEK, 1'b0, 32'h0, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h7fffffff, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PEEK, 1'b1, 32'h0, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h80000000, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'hffffffff, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'h0,        1'b0, NO_PIN},
      '{1'b0, 11'd0, FUNC_NOP,            1'b1, 32'hffffffff, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP,  1'b0, 32'h0,        1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP,  1'b0, 32'h0,        1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP,  1'b1, 32'h0,        1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP, 1'b1, 32'h0, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h80000000, 1'b1, 1'b1, 1'b0}},
      // zero capacity acts as a single entry
      '{1'b1, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'h0, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'h12345678, 1'b1,
        '{tess_pkg::STATUS_OK, 32'h0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'h55aa55aa, 1'b1,
        '{tess_pkg::STATUS_FULL, 32'h0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'hffffffff, 1'b1,
        '{tess_pkg::STATUS_FULL, 32'h0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP, 1'b0, 32'h0, 1'b1,
        '{tess_pkg::STATUS_EMPTY, 32'h0, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 11'd0, tess_pkg::FUNC_PEEK, 1'b1, 32'h0, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_POP,  1'b1, 32'h0, 1'b0, NO_PIN},
      // oversized capacity clamps to the full store
      '{1'b1, 11'd2047, tess_pkg::FUNC_PUSH, 1'b0, 32'h0, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'ha5a5a5a5, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PEEK, 1'b1, 32'h0,        1'b0, NO_PIN},
      '{1'b1, 11'd2, tess_pkg::FUNC_PUSH, 1'b0, 32'h0,        1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'h0000ffff, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b1, 32'hffff0000, 1'b0, NO_PIN},
      '{1'b0, 11'd0, tess_pkg::FUNC_PUSH, 1'b0, 32'h1, 1'b1,
        '{tess_pkg::STATUS_FULL, 32'h0, 1'b0, 1'b0, 1'b1}}
   };

   initial begin
      logic [CAP_W-1:0]  phase_cap;
      logic [FUNC_W-1:0] op;
      logic [DATA_W-1:0] val;
      int                run_left;
      bit                push_bias;
      int                pick;

      req_bus.valid = 1'b0;
      req_bus.func = tess_pkg::FUNC_PUSH;
      req_bus.stack_sel = 1'b0;
      req_bus.push_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity = '0;
      run_left = 0;
      push_bias = 1'b1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].cfg) begin
            write_capacity(plan[i].cap);
         end else begin
            send_item(plan[i].op, plan[i].sel, plan[i].val, plan[i].pinned, plan[i].res);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: phase_cap = 11'd1;
            1: phase_cap = 11'd2;
            2: phase_cap = 11'd2047;
            3: phase_cap = 11'd1024;
            4: phase_cap = 11'd1025;
            5: phase_cap = 11'd4;
            default: begin
               pick = $urandom_range(0, 9);
               if (pick < 7) phase_cap = CAP_W'($urandom_range(1, 24));
               else if (pick < 9) phase_cap = CAP_W'($urandom_range(25, 200));
               else phase_cap = CAP_W'($urandom_range(0, 2047));
            end
         endcase
         calm = (ph == NUM_PHASES - 1);
         gaps_on = !calm && ($urandom_range(0, 3) != 0);
         stall_on = !calm && ($urandom_range(0, 3) != 0);
         write_capacity(phase_cap);

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // alternate runs that mostly fill and runs that mostly drain
            if (run_left == 0) begin
               push_bias = $urandom_range(0, 1);
               run_left = $urandom_range(1, 24);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (push_bias) begin
               if (pick < 75) op = tess_pkg::FUNC_PUSH;
               else if (pick < 85) op = tess_pkg::FUNC_POP;
               else if (pick < 97) op = tess_pkg::FUNC_PEEK;
               else op = FUNC_NOP;
            end else begin
               if (pick < 15) op = tess_pkg::FUNC_PUSH;
               else if (pick < 65) op = tess_pkg::FUNC_POP;
               else if (pick < 97) op = tess_pkg::FUNC_PEEK;
               else op = FUNC_NOP;
            end
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0: val = 32'h0;
                  1: val = 32'h7fffffff;
                  2: val = 32'h80000000;
                  default: val = 32'hffffffff;
               endcase
            end else begin
               val = $urandom;
            end

            if (k == ITEMS_PER_PHASE / 2 && ph % 3 == 1) wait_drained();
            if (gaps_on && $urandom_range(0, 7) == 0) begin
               req_bus.valid = 1'b0;
               repeat ($urandom_range(1, 18)) @(negedge clock);
            end
            send_item(op, 1'($urandom_range(0, 1)), val, 1'b0, NO_PIN);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
